// ===== rtl/rwct_pkg.sv =====
// Shared widths, codes and types of the raycast wall column texturer.
// Used by the channel interfaces and every module of the block but the queue.
`default_nettype none

package rwct_pkg;

  localparam int MAX_IMAGE_HEIGHT = 64;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int COL_W = 12;
  localparam int DIST_W = 16;
  localparam int WFRAC_W = 16;
  localparam int OFF_W = 8;
  localparam int H_W = 7;
  localparam int ROW_W = 6;
  localparam int TEX_W = 11;
  localparam int TCOL_W = 10;
  localparam int IDX_W = 20;
  localparam int HALF_W = 14;
  localparam int DVS_W = 17;
  localparam int SPOS_W = 16;
  localparam int NEG_W = 14;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TEX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 2'd2;

  localparam logic [H_W-1:0] RST_IMAGE_HEIGHT = 7'd64;
  localparam logic [TEX_W-1:0] RST_TEXTURE_WIDTH = 11'd64;
  localparam logic [TEX_W-1:0] RST_TEXTURE_HEIGHT = 11'd64;
  localparam logic [TEX_W-1:0] MAX_TEXTURE_DIM = 11'd1024;

  typedef enum logic [2:0] {
    TEX_DOOR_FACE = 3'd0,
    TEX_DOOR_SIDE = 3'd1,
    TEX_SOUTH     = 3'd2,
    TEX_NORTH     = 3'd3,
    TEX_EAST      = 3'd4,
    TEX_WEST      = 3'd5
  } rwct_tex_e;

  typedef struct packed {
    logic [H_W-1:0]   h;
    logic [TEX_W-1:0] tw;
    logic [TEX_W-1:0] th;
  } rwct_cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [H_W-1:0]    start_row;
    logic [H_W-1:0]    end_row;
    rwct_tex_e         tex_id;
    logic [IDX_W-1:0]  base;
    logic [TCOL_W-1:0] th_m1;
  } rwct_col_t;

endpackage

`default_nettype wire

// ===== rtl/rwct_if.sv =====
// Valid/ready channel interfaces: ray hits in, textured pixels out.
// Depends on rwct_pkg for field widths.
`default_nettype none

interface rwct_hit_if;
  import rwct_pkg::*;
  logic                valid;
  logic                ready;
  logic [COL_W-1:0]    screen_column;
  logic [DIST_W-1:0]   wall_distance;
  logic [WFRAC_W-1:0]  wall_fraction;
  logic                hit_vertical;
  logic signed [1:0]   step_dir_x;
  logic signed [1:0]   step_dir_y;
  logic                hit_cell_is_door;
  logic                faced_cell_is_door;
  logic signed [OFF_W-1:0] view_offset;

  modport source (
    output valid, screen_column, wall_distance, wall_fraction, hit_vertical,
           step_dir_x, step_dir_y, hit_cell_is_door, faced_cell_is_door, view_offset,
    input  ready
  );
  modport sink (
    input  valid, screen_column, wall_distance, wall_fraction, hit_vertical,
           step_dir_x, step_dir_y, hit_cell_is_door, faced_cell_is_door, view_offset,
    output ready
  );
endinterface

interface rwct_pix_if;
  import rwct_pkg::*;
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   out_column;
  logic [ROW_W-1:0]   screen_row;
  logic [2:0]         texture_id;
  logic [IDX_W-1:0]   texel_index;
  logic               last;

  modport source (
    output valid, out_column, screen_row, texture_id, texel_index, last,
    input  ready
  );
  modport sink (
    input  valid, out_column, screen_row, texture_id, texel_index, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rwct_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Shared by the front end for half-height and texel step; uses rwct_pkg.
`default_nettype none

module rwct_div #(
  parameter int DW = rwct_pkg::FRAC_BITS_DEFAULT + rwct_pkg::TEX_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DW-1:0]                 dividend_i,
  input  logic [rwct_pkg::DVS_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [DW-1:0]                 quotient_o
);
  import rwct_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DW-1:0]    quo_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/rwct_front.sv =====
// Front end: takes one ray hit, picks the texture, derives half-height,
// texel step, row range, accumulator preload and texel column base.
// Depends on rwct_pkg, rwct_if and rwct_div.
`default_nettype none

module rwct_front #(
  parameter int FRACTION_BITS = rwct_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  rwct_hit_if.sink                                   hit,
  input  rwct_pkg::rwct_cfg_t                        cfg_i,
  input  logic                                       full_i,
  output logic                                       push_o,
  output rwct_pkg::rwct_col_t                        col_o,
  output logic [FRACTION_BITS+rwct_pkg::TEX_W-1:0]   acc_o,
  output logic [FRACTION_BITS+rwct_pkg::TEX_W-1:0]   step_o
);
  import rwct_pkg::*;

  localparam int ACC_W = FRACTION_BITS + TEX_W;
  localparam int PA_W = NEG_W + ACC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV1  = 3'd1;
  localparam logic [2:0] S_RANGE = 3'd2;
  localparam logic [2:0] S_DIV2  = 3'd3;
  localparam logic [2:0] S_MULA  = 3'd4;
  localparam logic [2:0] S_MULC  = 3'd5;
  localparam logic [2:0] S_MULB  = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  logic [2:0] state_q, state_d;

  logic [COL_W-1:0]        col_q;
  logic [WFRAC_W:0]        f_q;
  rwct_tex_e               tex_q;
  logic signed [OFF_W-1:0] off_q;
  logic [H_W-1:0]          h_q;
  logic [TEX_W-1:0]        tw_q;
  logic [TEX_W-1:0]        th_q;
  logic [HALF_W-1:0]       half_q;
  logic signed [SPOS_W-1:0] start_q;
  logic [H_W-1:0]          end_q;
  logic [ACC_W-1:0]        step_q;
  logic [ACC_W-1:0]        acc_q;
  logic [TCOL_W-1:0]       tcol_q;
  logic [IDX_W-1:0]        base_q;

  rwct_tex_e         tex_c;
  logic              mirror;
  logic [DIST_W-1:0] dist_fix;
  logic [WFRAC_W:0]  f_c;

  logic              div_start;
  logic              div_done;
  logic [ACC_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic [ACC_W-1:0]  div_quo;

  logic signed [SPOS_W-1:0] h_s, half_s, off_s, start_s, end_s;
  logic [H_W-1:0]    end_c;
  logic [SPOS_W-1:0] neg_full;
  logic [PA_W-1:0]   prod_a;
  logic [ACC_W-1:0]  acc_c;
  logic [27:0]       prod_c;
  logic [TEX_W-1:0]  tw_m1;
  logic [TEX_W-1:0]  th_m1;
  logic [20:0]       prod_b;
  logic              keep;
  logic              accept;

  assign hit.ready = (state_q == S_IDLE);
  assign accept    = hit.valid && (state_q == S_IDLE);

  always_comb begin
    priority if (hit.hit_cell_is_door) tex_c = TEX_DOOR_FACE;
    else if (hit.faced_cell_is_door)   tex_c = TEX_DOOR_SIDE;
    else if (!hit.hit_vertical)        tex_c = hit.step_dir_y[1] ? TEX_NORTH : TEX_SOUTH;
    else                               tex_c = hit.step_dir_x[1] ? TEX_WEST : TEX_EAST;
  end

  assign mirror = !hit.hit_cell_is_door &&
                  ((hit.hit_vertical && hit.step_dir_x[1]) ||
                   (!hit.hit_vertical && (hit.step_dir_y == 2'sb01)));
  assign f_c      = mirror ? (17'h10000 - {1'b0, hit.wall_fraction})
                           : {1'b0, hit.wall_fraction};
  assign dist_fix = (hit.wall_distance == '0) ? DIST_W'(1) : hit.wall_distance;

  assign div_dividend = (state_q == S_IDLE)
                      ? {{(ACC_W-H_W-8){1'b0}}, cfg_i.h, 8'd0}
                      : {th_q, {FRACTION_BITS{1'b0}}};
  assign div_divisor  = (state_q == S_IDLE)
                      ? {dist_fix, 1'b0}
                      : {2'd0, half_q, 1'b0};

  rwct_div #(.DW(ACC_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign h_s     = $signed({9'd0, h_q});
  assign half_s  = $signed({2'd0, half_q});
  assign off_s   = {{(SPOS_W-OFF_W){off_q[OFF_W-1]}}, off_q};
  assign start_s = h_s - half_s - off_s;
  assign end_s   = h_s + half_s - off_s;

  always_comb begin
    priority if (end_s < 0) end_c = '0;
    else if (end_s > h_s)   end_c = h_q;
    else                    end_c = end_s[H_W-1:0];
  end

  assign neg_full = -start_q;
  assign prod_a   = PA_W'(neg_full[NEG_W-1:0]) * PA_W'(step_q);
  assign acc_c    = (|prod_a[PA_W-1:ACC_W]) ? '1 : prod_a[ACC_W-1:0];

  assign tw_m1  = tw_q - TEX_W'(1);
  assign th_m1  = th_q - TEX_W'(1);
  assign prod_c = 28'(f_q) * 28'(tw_q);
  assign prod_b = 21'(tcol_q) * 21'(th_q);
  assign keep   = start_q[SPOS_W-1] ? (end_q != '0)
                                    : (start_q < $signed({9'd0, end_q}));

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    push_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (hit.valid) begin
          div_start = 1'b1;
          state_d   = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) state_d = S_RANGE;
      end
      S_RANGE: begin
        if (half_q != '0) begin
          div_start = 1'b1;
          state_d   = S_DIV2;
        end else begin
          state_d = S_MULA;
        end
      end
      S_DIV2: begin
        if (div_done) state_d = S_MULA;
      end
      S_MULA: state_d = S_MULC;
      S_MULC: state_d = S_MULB;
      S_MULB: state_d = S_PUSH;
      S_PUSH: begin
        if (!keep) begin
          state_d = S_IDLE;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= hit.screen_column;
      f_q   <= f_c;
      tex_q <= tex_c;
      off_q <= hit.view_offset;
      h_q   <= cfg_i.h;
      tw_q  <= cfg_i.tw;
      th_q  <= cfg_i.th;
    end
    if (state_q == S_DIV1 && div_done) half_q <= div_quo[HALF_W-1:0];
    if (state_q == S_RANGE) begin
      start_q <= start_s;
      end_q   <= end_c;
      if (half_q == '0) step_q <= '0;
    end
    if (state_q == S_DIV2 && div_done) step_q <= div_quo;
    if (state_q == S_MULA) acc_q <= start_q[SPOS_W-1] ? acc_c : '0;
    if (state_q == S_MULC) begin
      tcol_q <= (prod_c[27:16] > {1'b0, tw_m1}) ? tw_m1[TCOL_W-1:0] : prod_c[25:16];
    end
    if (state_q == S_MULB) base_q <= prod_b[IDX_W-1:0];
  end

  always_comb begin
    col_o.column    = col_q;
    col_o.start_row = start_q[SPOS_W-1] ? '0 : start_q[H_W-1:0];
    col_o.end_row   = end_q;
    col_o.tex_id    = tex_q;
    col_o.base      = base_q;
    col_o.th_m1     = th_m1[TCOL_W-1:0];
  end

  assign acc_o  = acc_q;
  assign step_o = step_q;

endmodule

`default_nettype wire

// ===== rtl/rwct_queue.sv =====
// Small register FIFO of column descriptors between front and back end.
// Depends on nothing but its parameters.
`default_nettype none

module rwct_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      if (pop_i)  rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/rwct_back.sv =====
// Back end: walks the row range of one column, one pixel a cycle unless the
// output stalls, into a registered output. Depends on rwct_pkg and rwct_if.
`default_nettype none

module rwct_back #(
  parameter int FRACTION_BITS = rwct_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       empty_i,
  output logic                                       pop_o,
  input  rwct_pkg::rwct_col_t                        col_i,
  input  logic [FRACTION_BITS+rwct_pkg::TEX_W-1:0]   acc_i,
  input  logic [FRACTION_BITS+rwct_pkg::TEX_W-1:0]   step_i,
  rwct_pix_if.source                                 pix
);
  import rwct_pkg::*;

  localparam int ACC_W = FRACTION_BITS + TEX_W;
  localparam logic [ACC_W:0] BIAS = (ACC_W+1)'((64'd33 << FRACTION_BITS) >> 16);

  logic              active_q;
  logic              out_valid_q;
  logic [H_W-1:0]    cur_q;
  logic [H_W-1:0]    end_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  step_q;
  logic [IDX_W-1:0]  base_q;
  logic [TCOL_W-1:0] thm1_q;
  logic [COL_W-1:0]  col_q;
  rwct_tex_e         tex_q;

  logic [COL_W-1:0]  o_col_q;
  logic [ROW_W-1:0]  o_row_q;
  rwct_tex_e         o_tex_q;
  logic [IDX_W-1:0]  o_idx_q;
  logic              o_last_q;

  logic              emit;
  logic              last_c;
  logic [ACC_W:0]    biased;
  logic [TEX_W:0]    row_raw;
  logic [TCOL_W-1:0] row_c;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_next;

  assign pop_o  = !active_q && !empty_i;
  assign emit   = active_q && (!out_valid_q || pix.ready);
  assign last_c = (cur_q + H_W'(1)) == end_q;

  assign biased   = {1'b0, acc_q} + BIAS;
  assign row_raw  = biased[ACC_W:FRACTION_BITS];
  assign row_c    = (row_raw > (TEX_W+1)'(thm1_q)) ? thm1_q : row_raw[TCOL_W-1:0];
  assign acc_sum  = {1'b0, acc_q} + {1'b0, step_q};
  assign acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      end_q       <= '0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        cur_q    <= col_i.start_row;
        end_q    <= col_i.end_row;
      end else if (emit) begin
        cur_q <= cur_q + H_W'(1);
        if (last_c) active_q <= 1'b0;
      end
      if (emit)           out_valid_q <= 1'b1;
      else if (pix.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      acc_q  <= acc_i;
      step_q <= step_i;
      base_q <= col_i.base;
      thm1_q <= col_i.th_m1;
      col_q  <= col_i.column;
      tex_q  <= col_i.tex_id;
    end else if (emit) begin
      acc_q <= acc_next;
    end
    if (emit) begin
      o_col_q  <= col_q;
      o_row_q  <= cur_q[ROW_W-1:0];
      o_tex_q  <= tex_q;
      o_idx_q  <= base_q + IDX_W'(row_c);
      o_last_q <= last_c;
    end
  end

  assign pix.valid       = out_valid_q;
  assign pix.out_column  = o_col_q;
  assign pix.screen_row  = o_row_q;
  assign pix.texture_id  = o_tex_q;
  assign pix.texel_index = o_idx_q;
  assign pix.last        = o_last_q;

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !active_q)
    else $error("column loaded while another is in progress");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cur_q < end_q))
    else $error("row counter left the column range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_c) |=> (!active_q && out_valid_q && o_last_q))
    else $error("last row did not close the column");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_q && (o_row_q == $past(cur_q[ROW_W-1:0]))))
    else $error("emitted row not presented");

endmodule

`default_nettype wire

// ===== rtl/raycast_wall_column_texturer_core.sv =====
// Top level of the raycast wall column texturer: configuration registers,
// front end, descriptor queue and back end. Depends on rwct_pkg, rwct_if,
// rwct_front, rwct_queue and rwct_back.
//
// One ray hit in, one pixel result per visible screen row out. The front end
// runs up to two serial divisions on one shared one-bit-per-cycle divider
// (half height, then texel step, which is skipped for a zero half-height)
// and three multiply steps, and takes no new hit until it has finished the
// last. The back end emits one row per cycle while the output is not
// stalled, after loading the column from the queue. A two-entry queue lets
// the two run concurrently. Columns with an empty row range produce no
// result. Configuration writes take effect for hits accepted afterward.
`default_nettype none

module raycast_wall_column_texturer_core #(
  parameter int FRACTION_BITS = rwct_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rwct_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rwct_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  rwct_hit_if.sink                          hit_i,
  rwct_pix_if.source                        pix_o
);
  import rwct_pkg::*;

  localparam int ACC_W = FRACTION_BITS + TEX_W;
  localparam int QW = $bits(rwct_col_t) + 2 * ACC_W;

  logic [H_W-1:0]   cfg_h_q;
  logic [TEX_W-1:0] cfg_tw_q;
  logic [TEX_W-1:0] cfg_th_q;
  rwct_cfg_t        cfg;

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  rwct_col_t        f_col;
  rwct_col_t        b_col;
  logic [ACC_W-1:0] f_acc, f_step, b_acc, b_step;
  logic [QW-1:0]    q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q  <= RST_IMAGE_HEIGHT;
      cfg_tw_q <= RST_TEXTURE_WIDTH;
      cfg_th_q <= RST_TEXTURE_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_HEIGHT:   cfg_h_q  <= cfg_data_i[H_W-1:0];
        CFG_TEXTURE_WIDTH:  cfg_tw_q <= cfg_data_i;
        CFG_TEXTURE_HEIGHT: cfg_th_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cfg_h_q == '0)               cfg.h = H_W'(1);
    else if (cfg_h_q > H_W'(MAX_IMAGE_HEIGHT)) cfg.h = H_W'(MAX_IMAGE_HEIGHT);
    else                                       cfg.h = cfg_h_q;
    priority if (cfg_tw_q == '0)        cfg.tw = TEX_W'(1);
    else if (cfg_tw_q > MAX_TEXTURE_DIM) cfg.tw = MAX_TEXTURE_DIM;
    else                                 cfg.tw = cfg_tw_q;
    priority if (cfg_th_q == '0)        cfg.th = TEX_W'(1);
    else if (cfg_th_q > MAX_TEXTURE_DIM) cfg.th = MAX_TEXTURE_DIM;
    else                                 cfg.th = cfg_th_q;
  end

  rwct_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hit    (hit_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .col_o  (f_col),
    .acc_o  (f_acc),
    .step_o (f_step)
  );

  assign q_wdata = {f_col, f_acc, f_step};

  rwct_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (empty)
  );

  assign {b_col, b_acc, b_step} = q_rdata;

  rwct_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .pop_o   (pop),
    .col_i   (b_col),
    .acc_i   (b_acc),
    .step_i  (b_step),
    .pix     (pix_o)
  );

endmodule

`default_nettype wire

// ===== dv/raycast_wall_column_texturer_core_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the raycast wall column texturer: tracks register writes,
// predicts the pixel rows of each ray hit transfer and compares pixel transfers.
// Depends on rwct_pkg and the rwct_hit_if / rwct_pix_if channel interfaces.

module raycast_wall_column_texturer_core_checker
  import rwct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rwct_hit_if                   hit_i,
  rwct_pix_if                   pix_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    hit_count_o,
  output int                    pix_count_o
);

  localparam int FRAC_BITS = FRAC_BITS_DEFAULT;
  localparam longint unsigned ACC_MAX = (64'd1 << (FRAC_BITS + 11)) - 1;
  localparam longint unsigned ROW_BIAS = (64'd33 << FRAC_BITS) >> 16;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    rwct_tex_e        tex;
    logic [IDX_W-1:0] index;
    logic             last;
  } pixel_t;

  logic [H_W-1:0]   img_rows;
  logic [TEX_W-1:0] tex_cols;
  logic [TEX_W-1:0] tex_rows;
  pixel_t           pending_pixels[$];
  int               failures;
  int               hits_seen;
  int               pixels_seen;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void predict_column(
    input logic [COL_W-1:0]          column,
    input logic [DIST_W-1:0]         dist_in,
    input logic [WFRAC_W-1:0]        frac,
    input logic                      vert,
    input logic [1:0]                sx,
    input logic [1:0]                sy,
    input logic                      hit_door,
    input logic                      faced_door,
    input logic signed [OFF_W-1:0]   offset
  );
    int unsigned       rows;
    int unsigned       tw;
    int unsigned       th;
    int unsigned       ray_dist;
    int unsigned       half;
    int unsigned       f;
    int unsigned       tcol;
    longint unsigned   step;
    longint unsigned   acc;
    longint unsigned   trow;
    int                top_row;
    int                bottom_row;
    rwct_tex_e         tex;
    logic [IDX_W-1:0]  base;
    pixel_t            px;
    rows = clamp_dim(32'(img_rows), 32'(MAX_IMAGE_HEIGHT));
    tw = clamp_dim(32'(tex_cols), 32'(MAX_TEXTURE_DIM));
    th = clamp_dim(32'(tex_rows), 32'(MAX_TEXTURE_DIM));

    if (hit_door) tex = TEX_DOOR_FACE;
    else if (faced_door) tex = TEX_DOOR_SIDE;
    else if (!vert) tex = sy[1] ? TEX_NORTH : TEX_SOUTH;
    else tex = sx[1] ? TEX_WEST : TEX_EAST;

    ray_dist = (dist_in == 0) ? 1 : 32'(dist_in);
    half = (rows * 256) / (2 * ray_dist);
    step = (half != 0) ? (longint'(th) << FRAC_BITS) / longint'(2 * half) : 0;

    acc = 0;
    top_row = int'(rows) - int'(half) - int'(offset);
    if (top_row < 0) begin
      acc = longint'(-top_row) * step;
      if (acc > ACC_MAX) acc = ACC_MAX;
      top_row = 0;
    end
    bottom_row = int'(rows) + int'(half) - int'(offset);
    if (bottom_row < 0) bottom_row = 0;
    if (bottom_row > int'(rows)) bottom_row = int'(rows);

    // mirror west faces and south-moving horizontal faces, never door faces
    f = 32'(frac);
    if (!hit_door && ((vert && sx[1]) || (!vert && !sy[1] && sy[0]))) f = 65536 - f;
    tcol = 32'((longint'(f) * tw) >> 16);
    if (tcol > tw - 1) tcol = tw - 1;
    base = IDX_W'(tcol * th);

    for (int r = top_row; r < bottom_row; r++) begin
      trow = (acc + ROW_BIAS) >> FRAC_BITS;
      if (trow > th - 1) trow = th - 1;
      px.column = column;
      px.row = r[ROW_W-1:0];
      px.tex = tex;
      px.index = base + trow[IDX_W-1:0];
      px.last = (r + 1 == bottom_row);
      pending_pixels.push_back(px);
      acc += step;
      if (acc > ACC_MAX) acc = ACC_MAX;
    end
  endfunction

  function automatic int field_mismatch(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want == got) return 0;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    pixel_t want;
    if (!rst_ni) begin
      img_rows = RST_IMAGE_HEIGHT;
      tex_cols = RST_TEXTURE_WIDTH;
      tex_rows = RST_TEXTURE_HEIGHT;
      pending_pixels.delete();
      failures = 0;
      hits_seen = 0;
      pixels_seen = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_HEIGHT: img_rows = cfg_data_i[H_W-1:0];
          CFG_TEXTURE_WIDTH: tex_cols = cfg_data_i;
          CFG_TEXTURE_HEIGHT: tex_rows = cfg_data_i;
          default: ;
        endcase
      end

      if (pix_i.valid && pix_i.ready) begin
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
          $display({"%0t ns: pixel transfer with nothing expected, expected none, ",
                    "actual col %0d row %0d index %0d"},
                   $time, pix_i.out_column, pix_i.screen_row, pix_i.texel_index);
          failures++;
        end else begin
          want = pending_pixels.pop_front();
          failures += field_mismatch("out_column", want.column, pix_i.out_column);
          failures += field_mismatch("screen_row", want.row, pix_i.screen_row);
          failures += field_mismatch("texture_id", want.tex, pix_i.texture_id);
          failures += field_mismatch("texel_index", want.index, pix_i.texel_index);
          failures += field_mismatch("last", want.last, pix_i.last);
        end
      end

      if (hit_i.valid && hit_i.ready) begin
        hits_seen++;
        predict_column(hit_i.screen_column, hit_i.wall_distance, hit_i.wall_fraction,
                       hit_i.hit_vertical, hit_i.step_dir_x, hit_i.step_dir_y,
                       hit_i.hit_cell_is_door, hit_i.faced_cell_is_door, hit_i.view_offset);
      end
    end
    fail_count_o <= failures;
    pending_o <= pending_pixels.size();
    hit_count_o <= hits_seen;
    pix_count_o <= pixels_seen;
  end

endmodule

// ===== dv/raycast_wall_column_texturer_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for raycast_wall_column_texturer_core: clock, reset, register
// writes, ray hit stimulus and pixel back-pressure; the checker gives the verdict.
// Depends on rwct_pkg, rwct_if, the core and raycast_wall_column_texturer_core_checker.

module raycast_wall_column_texturer_core_tb;
  import rwct_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [COL_W-1:0]   column;
    logic [DIST_W-1:0]  distance;
    logic [WFRAC_W-1:0] fraction;
    logic               vertical;
    logic [1:0]         step_x;
    logic [1:0]         step_y;
    logic               hit_door;
    logic               faced_door;
    logic [OFF_W-1:0]   offset;
  } ray_hit_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    hits_done;
  int                    pixels_done;
  int                    cycles = 0;
  int                    settings_used;
  int unsigned           rows_in_use;
  bit                    tx_idle_on;
  bit                    rx_idle_on;
  bit                    rx_hold_req;

  rwct_hit_if hit ();
  rwct_pix_if pix ();

  raycast_wall_column_texturer_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .hit_i      (hit),
    .pix_o      (pix)
  );

  raycast_wall_column_texturer_core_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .hit_i        (hit),
    .pix_i        (pix),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .hit_count_o  (hits_done),
    .pix_count_o  (pixels_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t ns: timeout after %0d cycles, %0d pixels still expected",
               $time, cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic ray_hit_t make_hit(input int column, input int distance, input int fraction,
                                        input int vertical, input int sx, input int sy,
                                        input int hit_door, input int faced_door,
                                        input int offset);
    ray_hit_t item;
    item.column = column[COL_W-1:0];
    item.distance = distance[DIST_W-1:0];
    item.fraction = fraction[WFRAC_W-1:0];
    item.vertical = vertical[0];
    item.step_x = sx[1:0];
    item.step_y = sy[1:0];
    item.hit_door = hit_door[0];
    item.faced_door = faced_door[0];
    item.offset = offset[OFF_W-1:0];
    return item;
  endfunction

  // keep most hits inside the visible band of the current height
  function automatic ray_hit_t random_hit();
    ray_hit_t    item;
    int unsigned pick;
    int          offset;
    pick = $urandom_range(0, 9);
    if (pick < 6) item.distance = DIST_W'($urandom_range(1, rows_in_use * 16));
    else if (pick < 8) item.distance = DIST_W'($urandom_range(0, 255));
    else item.distance = DIST_W'($urandom_range(0, 65535));
    item.column = COL_W'($urandom_range(0, 4095));
    item.fraction = WFRAC_W'($urandom_range(0, 65535));
    item.vertical = 1'($urandom_range(0, 1));
    item.step_x = 2'($urandom_range(0, 3));
    item.step_y = 2'($urandom_range(0, 3));
    item.hit_door = ($urandom_range(0, 3) == 0);
    item.faced_door = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 7)
      offset = int'($urandom_range(0, rows_in_use + rows_in_use / 2)) - int'(rows_in_use / 2);
    else
      offset = $urandom_range(0, 255);
    item.offset = offset[OFF_W-1:0];
    return item;
  endfunction

  task automatic send_hit(input ray_hit_t item);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      hit.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit.screen_column <= item.column;
    hit.wall_distance <= item.distance;
    hit.wall_fraction <= item.fraction;
    hit.hit_vertical <= item.vertical;
    hit.step_dir_x <= item.step_x;
    hit.step_dir_y <= item.step_y;
    hit.hit_cell_is_door <= item.hit_door;
    hit.faced_cell_is_door <= item.faced_door;
    hit.view_offset <= item.offset;
    hit.valid <= 1'b1;
    @(posedge clk);
    while (!hit.ready) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_hit(random_hit());
  endtask

  // drop valid, wait for every expected pixel, then let the front end drain
  task automatic settle();
    hit.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] h_val,
                               input logic [CFG_DATA_W-1:0] tw_val,
                               input logic [CFG_DATA_W-1:0] th_val);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_IMAGE_HEIGHT;
    cfg_data <= h_val;
    @(posedge clk);
    cfg_idx <= CFG_TEXTURE_WIDTH;
    cfg_data <= tw_val;
    @(posedge clk);
    cfg_idx <= CFG_TEXTURE_HEIGHT;
    cfg_data <= th_val;
    @(posedge clk);
    cfg_idx <= CFG_SPARE;
    cfg_data <= CFG_DATA_W'($urandom_range(0, 2047));
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_in_use = (h_val[H_W-1:0] == 0) ? 1 :
                  (h_val[H_W-1:0] > MAX_IMAGE_HEIGHT) ? MAX_IMAGE_HEIGHT : h_val[H_W-1:0];
    settings_used++;
  endtask

  initial begin : pixel_receiver
    int unsigned stall;
    pix.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pix.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        pix.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix.ready <= 1'b1;
      @(posedge clk);
      while (!pix.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    ray_hit_t directed[$];
    hit.valid = 1'b0;
    hit.screen_column = '0;
    hit.wall_distance = '0;
    hit.wall_fraction = '0;
    hit.hit_vertical = 1'b0;
    hit.step_dir_x = '0;
    hit.step_dir_y = '0;
    hit.hit_cell_is_door = 1'b0;
    hit.faced_cell_is_door = 1'b0;
    hit.view_offset = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_IMAGE_HEIGHT;
    cfg_data = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold_req = 1'b0;
    rows_in_use = RST_IMAGE_HEIGHT;
    settings_used = 1;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero distance, empty half-height, every texture and mirror case, clipping
    directed.push_back(make_hit(0, 0, 0, 0, -1, -1, 0, 0, 0));
    directed.push_back(make_hit(4095, 65535, 65535, 1, 1, 1, 1, 1, 0));
    directed.push_back(make_hit(1, 256, 16384, 1, 1, 0, 0, 0, 0));
    directed.push_back(make_hit(2, 512, 0, 1, -1, 0, 0, 0, 0));
    directed.push_back(make_hit(3, 512, 65535, 1, -2, 1, 0, 0, 0));
    directed.push_back(make_hit(4, 384, 40000, 1, 0, -1, 0, 0, 0));
    directed.push_back(make_hit(5, 384, 0, 0, 1, 1, 0, 0, 0));
    directed.push_back(make_hit(6, 384, 65535, 0, -1, 0, 0, 0, 0));
    directed.push_back(make_hit(7, 384, 12345, 0, 0, -2, 0, 0, 0));
    directed.push_back(make_hit(8, 300, 1000, 1, -1, 1, 1, 0, 0));
    directed.push_back(make_hit(9, 300, 1000, 0, 1, 1, 0, 1, 0));
    directed.push_back(make_hit(10, 300, 50000, 0, 0, 1, 1, 1, 5));
    directed.push_back(make_hit(11, 256, 30000, 1, 1, 1, 0, 0, 127));
    directed.push_back(make_hit(12, 256, 30000, 1, 1, 1, 0, 0, -128));
    directed.push_back(make_hit(13, 256, 30000, 0, -1, -1, 0, 0, 40));
    directed.push_back(make_hit(14, 128, 20000, 0, -1, 1, 0, 0, -30));
    directed.push_back(make_hit(15, 1, 32768, 1, -1, 0, 0, 0, 127));
    directed.push_back(make_hit(16, 16, 32768, 1, 1, 0, 0, 0, -128));
    directed.push_back(make_hit(17, 8192, 65535, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_hit(18, 8193, 100, 1, 1, 1, 0, 0, 100));
    directed.push_back(make_hit(19, 4095, 60000, 1, -1, -1, 0, 0, 60));
    directed.push_back(make_hit(2730, 21845, 43690, 1, 1, -2, 0, 0, 85));
    foreach (directed[i]) send_hit(directed[i]);
    run_random(25);

    apply_setting(11'd64, MAX_TEXTURE_DIM, MAX_TEXTURE_DIM);
    run_random(30);
    // stall the pixel side while hits keep coming, then drain fully mid-stream
    rx_hold_req = 1'b1;
    tx_idle_on = 1'b0;
    run_random(15);
    tx_idle_on = 1'b1;
    settle();
    run_random(10);

    apply_setting(11'd1, 11'd1, 11'd1);
    run_random(30);
    apply_setting(11'd0, 11'd0, 11'd0);
    run_random(25);

    apply_setting(11'h7FF, 11'h7FF, 11'h7FF);
    rx_idle_on = 1'b0;
    tx_idle_on = 1'b0;
    run_random(30);
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;

    apply_setting(11'd37, 11'd100, 11'd17);
    run_random(30);
    apply_setting(RST_IMAGE_HEIGHT, RST_TEXTURE_WIDTH, RST_TEXTURE_HEIGHT);
    run_random(25);
    settle();

    $display("Covered %0d ray hits and %0d pixel transfers over %0d register settings,",
             hits_done, pixels_done, settings_used);
    $display("with a long pixel-side hold, a full drain pause and idle-free stretches.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
